// ===== sv/vertex_cluster_representative_defines.svh =====
// Assertion helpers used by vcr_ctrl.
`ifndef VERTEX_CLUSTER_REPRESENTATIVE_DEFINES_SVH
`define VERTEX_CLUSTER_REPRESENTATIVE_DEFINES_SVH

// same-cycle implication
`define VCR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion check failed");

// next-cycle implication
`define VCR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion check failed");

`endif

// ===== sv/vcr_pkg.sv =====
package vcr_pkg;

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_LOOKUP = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [2:0] CSR_MIN_X     = 3'd0;
   localparam logic [2:0] CSR_MIN_Y     = 3'd1;
   localparam logic [2:0] CSR_MIN_Z     = 3'd2;
   localparam logic [2:0] CSR_CELL_SIZE = 3'd3;
   localparam logic [2:0] CSR_INV_SIZE  = 3'd4;
   localparam logic [2:0] CSR_DIMS      = 3'd5;
   localparam logic [2:0] CSR_STRATEGY  = 3'd6;

   localparam logic [63:0] SAT_SCORE = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int CELL_FULL_W = 18;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        weight;
      logic [15:0]        query_index;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [15:0] vertex_index;
      logic [14:0] cell_index;
      logic [15:0] representative;
      logic        remapped;
   } rsp_type;

   typedef struct packed {
      logic        occ;
      logic [15:0] vtx;
      logic [63:0] score;
   } cell_word_type;

   typedef struct packed {
      logic capture;
      logic rel;
      logic mul_lo;
      logic mul_hi;
      logic quot;
      logic csmul;
      logic diff;
      logic square;
      logic accum;
      logic cell_calc;
      logic cell_rd;
      logic cell_wr;
      logic vtx_rd;
      logic lk_cell;
      logic lk_res;
      logic sweep_step;
      logic res_zero;
      logic res_full;
      logic res_miss;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       full;
      logic       miss;
      logic       axis_last;
      logic       sweep_last;
   } sts_type;

endpackage

// ===== sv/vertex_cluster_representative.sv =====
// Vertex clustering representative unit. One item is in flight at a time.
// A load walks the three axes through one shared binning and distance unit,
// one axis after another (the 64-bit binning product is built from two 16x32
// partial products, then the centre offset is squared by one 32x32
// multiplier), then reads and updates the cell table; a new item can be
// accepted as soon as the result is valid. A lookup reads the vertex store,
// then the cell table, to form its result. A clear and the sweep after reset
// each write one cell table entry per cycle over all MAX_CELLS_PER_AXIS cubed
// entries (32768 at the default), during which no item is accepted.
// Configuration writes are taken at any cycle but belong between items, with
// no item in flight. A full result register holds the next result back.
module vertex_cluster_representative #(
   parameter int MAX_CELLS_PER_AXIS = 32,
   parameter int MAX_VERTICES       = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vcr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vcr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);

   vcr_pkg::cmd_type cmd;
   vcr_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   vcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   vcr_datapath #(
      .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS),
      .MAX_VERTICES       (MAX_VERTICES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

// ===== sv/vcr_ctrl.sv =====
`include "vertex_cluster_representative_defines.svh"

module vcr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  vcr_pkg::sts_type sts,
   output vcr_pkg::cmd_type cmd
);

   localparam logic [4:0] S_INIT = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_DEC  = 5'd2;
   localparam logic [4:0] S_REL  = 5'd3;
   localparam logic [4:0] S_MLO  = 5'd4;
   localparam logic [4:0] S_MHI  = 5'd5;
   localparam logic [4:0] S_QUO  = 5'd6;
   localparam logic [4:0] S_CSM  = 5'd7;
   localparam logic [4:0] S_DIF  = 5'd8;
   localparam logic [4:0] S_SQR  = 5'd9;
   localparam logic [4:0] S_ACC  = 5'd10;
   localparam logic [4:0] S_CELL = 5'd11;
   localparam logic [4:0] S_CRD  = 5'd12;
   localparam logic [4:0] S_UPD  = 5'd13;
   localparam logic [4:0] S_VRD  = 5'd14;
   localparam logic [4:0] S_LCL  = 5'd15;
   localparam logic [4:0] S_LRD  = 5'd16;
   localparam logic [4:0] S_LRS  = 5'd17;
   localparam logic [4:0] S_CLR  = 5'd18;
   localparam logic [4:0] S_RSP  = 5'd19;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DEC;
            end
         end
         S_DEC: begin
            case (sts.mode)
               vcr_pkg::MODE_LOAD: begin
                  if (sts.full) begin
                     cmd.res_full = 1'b1;
                     state_in     = S_RSP;
                  end else begin
                     state_in = S_REL;
                  end
               end
               vcr_pkg::MODE_LOOKUP: begin
                  if (sts.miss) begin
                     cmd.res_miss = 1'b1;
                     state_in     = S_RSP;
                  end else begin
                     state_in = S_VRD;
                  end
               end
               vcr_pkg::MODE_CLEAR: state_in = S_CLR;
               default: begin
                  cmd.res_zero = 1'b1;
                  state_in     = S_RSP;
               end
            endcase
         end
         S_REL: begin
            cmd.rel  = 1'b1;
            state_in = S_MLO;
         end
         S_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MHI;
         end
         S_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_QUO;
         end
         S_QUO: begin
            cmd.quot = 1'b1;
            state_in = S_CSM;
         end
         S_CSM: begin
            cmd.csmul = 1'b1;
            state_in  = S_DIF;
         end
         S_DIF: begin
            cmd.diff = 1'b1;
            state_in = S_SQR;
         end
         S_SQR: begin
            cmd.square = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.accum = 1'b1;
            state_in  = sts.axis_last ? S_CELL : S_REL;
         end
         S_CELL: begin
            cmd.cell_calc = 1'b1;
            state_in      = S_CRD;
         end
         S_CRD: begin
            cmd.cell_rd = 1'b1;
            state_in    = S_UPD;
         end
         S_UPD: begin
            cmd.cell_wr = 1'b1;
            state_in    = S_RSP;
         end
         S_VRD: begin
            cmd.vtx_rd = 1'b1;
            state_in   = S_LCL;
         end
         S_LCL: begin
            cmd.lk_cell = 1'b1;
            state_in    = S_LRD;
         end
         S_LRD: begin
            cmd.cell_rd = 1'b1;
            state_in    = S_LRS;
         end
         S_LRS: begin
            cmd.lk_res = 1'b1;
            state_in   = S_RSP;
         end
         S_CLR: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               cmd.res_zero = 1'b1;
               state_in     = S_RSP;
            end
         end
         S_RSP: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `VCR_ASSERT_IMP(a_load_into_free, clock, reset, cmd.rsp_load, !rsp_valid_ff)
   `VCR_ASSERT_NXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)
   `VCR_ASSERT_NXT(a_axis_loop, clock, reset, state_ff == S_ACC && !sts.axis_last, state_ff == S_REL)

endmodule

// ===== sv/vcr_datapath.sv =====
module vcr_datapath #(
   parameter int MAX_CELLS_PER_AXIS = 32,
   parameter int MAX_VERTICES       = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  vcr_pkg::cmd_type cmd,
   output vcr_pkg::sts_type sts,
   input  vcr_pkg::req_type req_data,
   output vcr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);

   localparam int NUM_CELLS = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS;
   localparam int CW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int VCAP = (MAX_VERTICES < 65536) ? MAX_VERTICES : 65536;
   localparam int VAW  = $clog2(VCAP);
   localparam int CNW  = $clog2(VCAP + 1);
   localparam int VCW  = (CW < 16) ? CW : 16;
   localparam int CELL_FULL_W_L = vcr_pkg::CELL_FULL_W;

   // configuration
   logic [31:0] min_x_ff, min_y_ff, min_z_ff, inv_ff;
   logic [30:0] cell_size_ff;
   logic [17:0] dims_ff;
   logic        strategy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff     <= '0;
         min_y_ff     <= '0;
         min_z_ff     <= '0;
         cell_size_ff <= 31'd65536;
         inv_ff       <= 32'd65536;
         dims_ff      <= 18'd133152;
         strategy_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            vcr_pkg::CSR_MIN_X:     min_x_ff     <= csr_data;
            vcr_pkg::CSR_MIN_Y:     min_y_ff     <= csr_data;
            vcr_pkg::CSR_MIN_Z:     min_z_ff     <= csr_data;
            vcr_pkg::CSR_CELL_SIZE: cell_size_ff <= csr_data[30:0];
            vcr_pkg::CSR_INV_SIZE:  inv_ff       <= csr_data;
            vcr_pkg::CSR_DIMS:      dims_ff      <= csr_data[17:0];
            vcr_pkg::CSR_STRATEGY:  strategy_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // item and per-axis pipeline registers
   vcr_pkg::req_type item_ff;
   logic [1:0]       axis_ff;
   logic [32:0]      rel_ff;
   logic [47:0]      plo_ff, phi_ff;
   logic [5:0]       cur_idx_ff;
   logic [5:0]       idx_ff [3];
   logic [37:0]      csm_ff;
   logic [31:0]      abs_ff;
   logic             big_ff;
   logic [63:0]      sq_ff, score_ff, fscore_ff;
   logic [CW-1:0]    cell_ff;
   logic [CNW-1:0]   count_ff;
   logic [CW-1:0]    sweep_ff;
   logic [VCW-1:0]   vrd_ff;
   vcr_pkg::cell_word_type crd_ff;
   vcr_pkg::rsp_type res_ff, rsp_ff;

   logic [31:0] pos_sel, min_sel, relp, quo;
   logic [5:0]  dim_raw, dmax, idx_w;
   logic [6:0]  dimc;
   logic [63:0] prod, sq_w;
   logic [39:0] dif, dabs;
   logic [64:0] sum;
   logic [CELL_FULL_W_L-1:0] cell_full;
   logic [15:0] vi;
   logic        win;
   logic [15:0] rep_w;

   always_comb begin
      case (axis_ff)
         2'd0: begin
            pos_sel = item_ff.pos_x;
            min_sel = min_x_ff;
            dim_raw = dims_ff[5:0];
         end
         2'd1: begin
            pos_sel = item_ff.pos_y;
            min_sel = min_y_ff;
            dim_raw = dims_ff[11:6];
         end
         default: begin
            pos_sel = item_ff.pos_z;
            min_sel = min_z_ff;
            dim_raw = dims_ff[17:12];
         end
      endcase
   end

   assign relp = (!rel_ff[32] && (rel_ff != '0)) ? rel_ff[31:0] : '0;
   assign prod = {phi_ff, 16'b0} + {16'b0, plo_ff};
   assign quo  = prod[63:32];

   always_comb begin
      dimc = {1'b0, dim_raw};
      if (dim_raw == '0) dimc = 7'd1;
      else if (dimc > 7'(MAX_CELLS_PER_AXIS)) dimc = 7'(MAX_CELLS_PER_AXIS);
   end
   assign dmax  = 6'(dimc - 7'd1);
   assign idx_w = (quo > {26'b0, dmax}) ? dmax : quo[5:0];

   // twice the offset from the cell centre, in half-LSB units
   assign dif  = {{6{rel_ff[32]}}, rel_ff, 1'b0} - {2'b0, csm_ff};
   assign dabs = dif[39] ? (40'd0 - dif) : dif;
   assign sq_w = abs_ff * abs_ff;
   assign sum  = {1'b0, score_ff} + {1'b0, sq_ff};

   assign cell_full = CELL_FULL_W_L'((int'(idx_ff[0]) * MAX_CELLS_PER_AXIS + int'(idx_ff[1]))
                                     * MAX_CELLS_PER_AXIS + int'(idx_ff[2]));

   assign vi    = 16'(count_ff);
   assign win   = !crd_ff.occ || (fscore_ff < crd_ff.score);
   assign rep_w = win ? vi : crd_ff.vtx;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff  <= req_data;
         score_ff <= '0;
      end
      if (cmd.rel) rel_ff <= {pos_sel[31], pos_sel} - {min_sel[31], min_sel};
      if (cmd.mul_lo) plo_ff <= relp[15:0] * inv_ff;
      if (cmd.mul_hi) phi_ff <= relp[31:16] * inv_ff;
      if (cmd.quot) begin
         cur_idx_ff <= idx_w;
         case (axis_ff)
            2'd0:    idx_ff[0] <= idx_w;
            2'd1:    idx_ff[1] <= idx_w;
            default: idx_ff[2] <= idx_w;
         endcase
      end
      if (cmd.csmul) csm_ff <= {cur_idx_ff, 1'b1} * cell_size_ff;
      if (cmd.diff) begin
         abs_ff <= dabs[31:0];
         big_ff <= |dabs[39:32];
      end
      if (cmd.square) sq_ff <= big_ff ? vcr_pkg::SAT_SCORE : sq_w;
      if (cmd.accum) score_ff <= sum[64] ? vcr_pkg::SAT_SCORE : sum[63:0];
      if (cmd.cell_calc) begin
         cell_ff   <= CW'(cell_full);
         fscore_ff <= strategy_ff ? {32'hFFFF_FFFF, ~item_ff.weight} : score_ff;
      end
      if (cmd.lk_cell) cell_ff <= CW'(vrd_ff);
      if (cmd.cell_wr) begin
         res_ff.status         <= 1'b0;
         res_ff.vertex_index   <= vi;
         res_ff.cell_index     <= 15'(cell_ff);
         res_ff.representative <= rep_w;
         res_ff.remapped       <= (rep_w != vi);
      end
      if (cmd.lk_res) begin
         res_ff.status         <= 1'b0;
         res_ff.vertex_index   <= item_ff.query_index;
         res_ff.cell_index     <= 15'(cell_ff);
         res_ff.representative <= crd_ff.occ ? crd_ff.vtx : item_ff.query_index;
         res_ff.remapped       <= crd_ff.occ && (crd_ff.vtx != item_ff.query_index);
      end
      if (cmd.res_miss)
         res_ff <= {1'b0, item_ff.query_index, 15'd0, item_ff.query_index, 1'b0};
      if (cmd.res_full) res_ff <= {1'b1, 48'd0};
      if (cmd.res_zero) res_ff <= '0;
      if (cmd.rsp_load) rsp_ff <= res_ff;
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff  <= '0;
         count_ff <= '0;
         sweep_ff <= '0;
      end else begin
         if (cmd.capture) axis_ff <= '0;
         else if (cmd.accum) axis_ff <= axis_ff + 2'd1;
         if (cmd.cell_wr) count_ff <= count_ff + CNW'(1);
         if (cmd.sweep_step) begin
            if (sweep_ff == CW'(NUM_CELLS - 1)) sweep_ff <= '0;
            else sweep_ff <= sweep_ff + CW'(1);
         end
      end
   end

   // cell table and vertex-to-cell store
   vcr_pkg::cell_word_type cell_mem [NUM_CELLS];
   logic [VCW-1:0]         vtx_mem  [VCAP];

   always_ff @(posedge clock) begin
      if (cmd.sweep_step) cell_mem[sweep_ff] <= '0;
      else if (cmd.cell_wr && win) cell_mem[cell_ff] <= {1'b1, vi, fscore_ff};
      if (cmd.cell_rd) crd_ff <= cell_mem[cell_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.cell_wr) vtx_mem[count_ff[VAW-1:0]] <= VCW'(cell_ff);
      if (cmd.vtx_rd) vrd_ff <= vtx_mem[item_ff.query_index[VAW-1:0]];
   end

   assign sts.mode       = item_ff.mode;
   assign sts.full       = (count_ff >= CNW'(VCAP));
   assign sts.miss       = (32'(item_ff.query_index) >= 32'(count_ff));
   assign sts.axis_last  = (axis_ff == 2'd2);
   assign sts.sweep_last = (sweep_ff == CW'(NUM_CELLS - 1));
   assign rsp_data       = rsp_ff;

endmodule
